### hw/rtl/sem_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 16;
    localparam int PIX_W      = 24;
    localparam int ROOT_STEPS = 11;
    localparam int CNT_W      = 4;

    localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 16'd768;

    localparam logic       REQ_PIXEL  = 1'b0;
    localparam logic       REQ_DRAIN  = 1'b1;
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_GRAD,
        S_SQR,
        S_ROOT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic grad;
        logic sqr;
        logic root;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic emit;
        logic interior;
        logic out_free;
    } dp_sts_t;
endpackage
`default_nettype wire

### hw/rtl/sem_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module sem_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sem_pkg::dp_sts_t sts,
    output sem_pkg::dp_cmd_t      cmd
);
    sem_pkg::state_t state_reg, state_next;
    logic [sem_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic root_done;

    assign root_done = (cnt_reg == sem_pkg::CNT_W'(sem_pkg::ROOT_STEPS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sem_pkg::S_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            sem_pkg::S_IDLE: begin
                if (s_valid) state_next = sem_pkg::S_SHIFT;
            end
            sem_pkg::S_SHIFT: begin
                if (!sts.emit) state_next = sem_pkg::S_IDLE;
                else if (sts.interior) state_next = sem_pkg::S_GRAD;
                else state_next = sem_pkg::S_FIN;
            end
            sem_pkg::S_GRAD: state_next = sem_pkg::S_SQR;
            sem_pkg::S_SQR: begin
                state_next = sem_pkg::S_ROOT;
                cnt_next   = '0;
            end
            sem_pkg::S_ROOT: begin
                cnt_next = cnt_reg + 1'b1;
                if (root_done) state_next = sem_pkg::S_FIN;
            end
            sem_pkg::S_FIN: begin
                if (sts.out_free) state_next = sem_pkg::S_IDLE;
            end
            default: state_next = sem_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            sem_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            sem_pkg::S_SHIFT: cmd.shift = 1'b1;
            sem_pkg::S_GRAD:  cmd.grad  = 1'b1;
            sem_pkg::S_SQR:   cmd.sqr   = 1'b1;
            sem_pkg::S_ROOT:  cmd.root  = 1'b1;
            sem_pkg::S_FIN:   cmd.out_load = sts.out_free;
            default: cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/sem_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module sem_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             s_req_type,
    input  wire logic [7:0]       s_pixel_red,
    input  wire logic [7:0]       s_pixel_green,
    input  wire logic [7:0]       s_pixel_blue,
    input  wire sem_pkg::dp_cmd_t cmd,
    output sem_pkg::dp_sts_t      sts,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_out_red,
    output logic [7:0]            m_out_green,
    output logic [7:0]            m_out_blue,
    output logic                  m_frame_last
);
    localparam int CW = sem_pkg::COL_W;
    localparam int WW = sem_pkg::WIDTH_W;
    localparam int HW = sem_pkg::HEIGHT_W;
    localparam int PW = sem_pkg::PIX_W;

    logic [WW-1:0] fw_reg;
    logic [HW-1:0] fh_reg;
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    logic          req_reg;
    logic [PW-1:0] px_reg;

    logic [2*PW-1:0] mem [sem_pkg::MAX_WIDTH];
    logic [2*PW-1:0] rd_reg;

    logic [PW-1:0] win_reg [3][3];
    logic [CW-1:0] in_col_reg;
    logic [HW-1:0] in_row_reg;
    logic [CW-1:0] out_col_reg;
    logic [HW-1:0] out_row_reg;
    logic [WW-1:0] drain_reg;

    logic          drop, emit_c, interior, last, col_end;
    logic [PW-1:0] new_px;

    logic          int_reg, last_reg;
    logic [PW-1:0] center_reg;

    logic signed [10:0] gx_reg [3];
    logic signed [10:0] gy_reg [3];
    logic [20:0] rem_reg [3];
    logic [21:0] res_reg [3];
    logic [20:0] bit_reg;

    logic signed [10:0] gx_c [3];
    logic signed [10:0] gy_c [3];
    logic signed [21:0] sqx [3];
    logic signed [21:0] sqy [3];
    logic [21:0] trial [3];
    logic [11:0] rnd [3];
    logic [7:0]  fin [3];

    logic          m_valid_reg;
    logic [7:0]    o_red_reg, o_green_reg, o_blue_reg;
    logic          o_last_reg;

    always_comb begin
        if (fw_reg == '0) w_eff = WW'(1);
        else if (fw_reg > WW'(sem_pkg::MAX_WIDTH)) w_eff = WW'(sem_pkg::MAX_WIDTH);
        else w_eff = fw_reg;
        h_eff = (fh_reg == '0) ? HW'(1) : fh_reg;
    end

    always_comb begin
        drop = (req_reg == sem_pkg::REQ_DRAIN) ? (drain_reg == '0) : (drain_reg != '0);
        if (req_reg == sem_pkg::REQ_DRAIN)
            emit_c = !((h_eff == HW'(1)) && (drain_reg == w_eff + 1'b1));
        else
            emit_c = (in_row_reg >= HW'(2)) || ((in_row_reg == HW'(1)) && (in_col_reg != '0));
        new_px   = (req_reg == sem_pkg::REQ_DRAIN) ? '0 : px_reg;
        col_end  = ({1'b0, in_col_reg} + 1'b1) >= w_eff;
        interior = (w_eff >= WW'(3)) && (h_eff >= HW'(3)) && (out_row_reg != '0) &&
                   (({1'b0, out_row_reg} + 17'd2) <= {1'b0, h_eff}) && (out_col_reg != '0) &&
                   (({1'b0, out_col_reg} + WW'(2)) <= w_eff);
        last     = (out_row_reg == h_eff - 1'b1) && ({1'b0, out_col_reg} == w_eff - 1'b1);
        sts.emit     = !drop && emit_c;
        sts.interior = interior;
        sts.out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[in_col_reg];
        if (cmd.shift && !drop) mem[in_col_reg] <= {rd_reg[PW-1:0], new_px};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= s_req_type;
            px_reg  <= {s_pixel_red, s_pixel_green, s_pixel_blue};
        end
        if (cmd.shift) begin
            int_reg  <= interior;
            last_reg <= last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= sem_pkg::RESET_WIDTH;
            fh_reg      <= sem_pkg::RESET_HEIGHT;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            drain_reg   <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
        end else if (cfg_we && (cfg_index == sem_pkg::CFG_WIDTH ||
                                cfg_index == sem_pkg::CFG_HEIGHT)) begin
            if (cfg_index == sem_pkg::CFG_WIDTH) fw_reg <= cfg_data[WW-1:0];
            else fh_reg <= cfg_data;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            drain_reg   <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++) win_reg[r][c] <= '0;
        end else if (cmd.shift && !drop) begin
            for (int r = 0; r < 3; r++) begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= rd_reg[2*PW-1:PW];
            win_reg[1][2] <= rd_reg[PW-1:0];
            win_reg[2][2] <= new_px;
            if (req_reg == sem_pkg::REQ_DRAIN) begin
                drain_reg <= drain_reg - 1'b1;
                if (drain_reg == WW'(1)) begin
                    in_col_reg <= '0;
                    in_row_reg <= '0;
                end else begin
                    in_col_reg <= col_end ? '0 : in_col_reg + 1'b1;
                end
            end else if (col_end) begin
                in_col_reg <= '0;
                if (({1'b0, in_row_reg} + 1'b1) >= {1'b0, h_eff}) begin
                    in_row_reg <= '0;
                    drain_reg  <= w_eff + 1'b1;
                end else begin
                    in_row_reg <= in_row_reg + 1'b1;
                end
            end else begin
                in_col_reg <= in_col_reg + 1'b1;
            end
            if (emit_c) begin
                if (last) begin
                    out_col_reg <= '0;
                    out_row_reg <= '0;
                end else if ({1'b0, out_col_reg} == w_eff - 1'b1) begin
                    out_col_reg <= '0;
                    out_row_reg <= out_row_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift && !drop) center_reg <= win_reg[1][2];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            logic [9:0] top, bot, lft, rgt;
            top = {2'b0, win_reg[0][0][8*k +: 8]} + {1'b0, win_reg[0][1][8*k +: 8], 1'b0} +
                  {2'b0, win_reg[0][2][8*k +: 8]};
            bot = {2'b0, win_reg[2][0][8*k +: 8]} + {1'b0, win_reg[2][1][8*k +: 8], 1'b0} +
                  {2'b0, win_reg[2][2][8*k +: 8]};
            lft = {2'b0, win_reg[0][0][8*k +: 8]} + {1'b0, win_reg[1][0][8*k +: 8], 1'b0} +
                  {2'b0, win_reg[2][0][8*k +: 8]};
            rgt = {2'b0, win_reg[0][2][8*k +: 8]} + {1'b0, win_reg[1][2][8*k +: 8], 1'b0} +
                  {2'b0, win_reg[2][2][8*k +: 8]};
            gx_c[k]  = $signed({1'b0, bot}) - $signed({1'b0, top});
            gy_c[k]  = $signed({1'b0, rgt}) - $signed({1'b0, lft});
            sqx[k]   = gx_reg[k] * gx_reg[k];
            sqy[k]   = gy_reg[k] * gy_reg[k];
            trial[k] = res_reg[k] + {1'b0, bit_reg};
            rnd[k]   = {1'b0, res_reg[k][10:0]} +
                       12'({20'b0, ({10'b0, res_reg[k][10:0]} < rem_reg[k])});
            fin[k]   = (rnd[k] > 12'd255) ? 8'd255 : rnd[k][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.sqr) bit_reg <= 21'h100000;
        else if (cmd.root) bit_reg <= bit_reg >> 2;
        for (int k = 0; k < 3; k++) begin
            if (cmd.grad) begin
                gx_reg[k] <= gx_c[k];
                gy_reg[k] <= gy_c[k];
            end
            if (cmd.sqr) begin
                rem_reg[k] <= sqx[k][20:0] + sqy[k][20:0];
                res_reg[k] <= '0;
            end else if (cmd.root) begin
                if ({1'b0, rem_reg[k]} >= trial[k]) begin
                    rem_reg[k] <= rem_reg[k] - trial[k][20:0];
                    res_reg[k] <= (res_reg[k] >> 1) + {1'b0, bit_reg};
                end else begin
                    res_reg[k] <= res_reg[k] >> 1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            o_red_reg   <= int_reg ? fin[2] : center_reg[23:16];
            o_green_reg <= int_reg ? fin[1] : center_reg[15:8];
            o_blue_reg  <= int_reg ? fin[0] : center_reg[7:0];
            o_last_reg  <= last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_red    = o_red_reg;
    assign m_out_green  = o_green_reg;
    assign m_out_blue   = o_blue_reg;
    assign m_frame_last = o_last_reg;
endmodule
`default_nettype wire

### hw/rtl/sobel_edge_magnitude_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// Sobel edge magnitude on an RGB raster stream, one word at a time. A border
// or pass-through word goes from the shift state to the result register; an
// interior pixel takes the gradient, square and 11 bit-pair square root steps
// on all three channels at once; a word with no result ends after the shift.
// Results lag the input by width+1 words; send width+1 drain words after each
// frame. A register write restarts the frame and must be issued while idle.
module sobel_edge_magnitude_rgb (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_req_type,
    input  wire logic [7:0]  s_pixel_red,
    input  wire logic [7:0]  s_pixel_green,
    input  wire logic [7:0]  s_pixel_blue,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_red,
    output logic [7:0]       m_out_green,
    output logic [7:0]       m_out_blue,
    output logic             m_frame_last
);
    sem_pkg::dp_cmd_t cmd;
    sem_pkg::dp_sts_t sts;

    sem_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    sem_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_req_type    (s_req_type),
        .s_pixel_red   (s_pixel_red),
        .s_pixel_green (s_pixel_green),
        .s_pixel_blue  (s_pixel_blue),
        .cmd           (cmd),
        .sts           (sts),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_red     (m_out_red),
        .m_out_green   (m_out_green),
        .m_out_blue    (m_out_blue),
        .m_frame_last  (m_frame_last)
    );
endmodule
`default_nettype wire
